// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off while in reset.
`define QOLM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled at the rising clock edge, off while in reset.
`define QOLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/qolm_pkg.sv =====
// Package for the queue occupancy monitor: widths, codes and the
// command and status bundles between controller and datapath. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package qolm_pkg;

	localparam int KIND_W      = 2;
	localparam int IN_TIME_W   = 32;
	localparam int SVC_W       = 24;
	localparam int CNT32_W     = 32;
	localparam int AREA_W      = 64;
	localparam int BUSY_W      = 56;
	localparam int OUT48_W     = 48;
	localparam int OUT32_W     = 32;
	localparam int PEAK_W      = 16;
	localparam int S_TDATA_W   = 56;
	localparam int M_TDATA_W   = 224;
	localparam int M_TUSER_W   = 3;
	localparam int MUL_STEP_W  = 16;

	localparam int TIME_BITS_DEF  = 32;
	localparam int COUNT_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic [AREA_W-1:0] ERR_POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [AREA_W-1:0] ERR_NEG_MAG = 64'h0000_8000_0000_0000;

	typedef enum logic [KIND_W-1:0] {
		KIND_ARRIVAL = 2'd0,
		KIND_DEPART  = 2'd1,
		KIND_REPORT  = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_ZERO_TIME   = 2'd1,
		STATUS_NO_ARRIVALS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEL_OCC  = 2'd0,
		SEL_ARR  = 2'd1,
		SEL_DEP  = 2'd2,
		SEL_TERM = 2'd3
	} mul_sel_t;

	typedef enum logic [1:0] {
		QS_MIS  = 2'd0,
		QS_MT   = 2'd1,
		QS_LAM  = 2'd2,
		QS_UTIL = 2'd3
	} quo_sel_t;

	typedef struct packed {
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     report;
		logic     div_start;
		quo_sel_t div_sel;
		logic     count_update;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic      mul_done;
		logic      div_done;
		req_kind_t kind;
		logic      empty;
	} stat_t;

endpackage

`default_nettype wire

// ===== hdl/qolm_mul.sv =====
// Multi-cycle multiplier of the queue occupancy monitor, 16 multiplier bits per
// cycle, most significant chunk first. Depends on qolm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qolm_mul
	import qolm_pkg::*;
#(
	parameter int A_W = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [A_W-1:0]         a,
	input  logic [CNT32_W-1:0]     b,
	output logic [A_W+CNT32_W-1:0] prod,
	output logic                   done
);

	localparam int P_W   = A_W + CNT32_W;
	localparam int STEPS = CNT32_W / MUL_STEP_W;
	localparam int CN_W  = $clog2(STEPS + 1);

	logic [P_W-1:0]     acc_q;
	logic [A_W-1:0]     a_q;
	logic [CNT32_W-1:0] b_q;
	logic [CN_W-1:0]    cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CN_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CN_W'(1);
				if (cnt_q == CN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= (acc_q << MUL_STEP_W)
				+ (P_W'(a_q) * P_W'(b_q[CNT32_W-1 -: MUL_STEP_W]));
			b_q   <= b_q << MUL_STEP_W;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== hdl/qolm_div.sv =====
// Bit-serial restoring divider of the queue occupancy monitor: quotient of
// num * 2^FRAC_W / den, one bit per cycle. Depends on qolm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qolm_div
	import qolm_pkg::*;
#(
	parameter int NUM_W  = AREA_W,
	parameter int DEN_W  = 32,
	parameter int FRAC_W = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [NUM_W-1:0]         num,
	input  logic [DEN_W-1:0]         den,
	output logic [NUM_W+FRAC_W-1:0]  quo,
	output logic                     done
);

	localparam int N_W  = NUM_W + FRAC_W;
	localparam int CN_W = $clog2(N_W + 1);

	logic [N_W-1:0]   qn_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CN_W-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, qn_q[N_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CN_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CN_W'(1);
				if (cnt_q == CN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qn_q  <= {num, {FRAC_W{1'b0}}};
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			qn_q  <= {qn_q[N_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign quo  = qn_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== hdl/qolm_dp.sv =====
// Datapath of the queue occupancy monitor: counts, areas, report temporaries and
// the result register, with the shared multiplier and divider. Depends on qolm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qolm_dp
	import qolm_pkg::*;
#(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_load,
	input  logic [KIND_W-1:0]         in_kind,
	input  logic [IN_TIME_W-1:0]      in_time,
	input  logic [SVC_W-1:0]          in_svc,
	input  cmd_t                      cmd,
	output stat_t                     stat,
	output logic [OUT48_W-1:0]        mean_in_system,
	output logic [OUT48_W-1:0]        mean_time_in_system,
	output logic [OUT32_W-1:0]        arrival_rate,
	output logic signed [OUT48_W-1:0] little_error,
	output logic [OUT32_W-1:0]        utilization,
	output logic [PEAK_W-1:0]         peak_in_system,
	output status_t                   status,
	output logic                      saturated
);

	localparam int MUL_A_W = (TIME_BITS > OUT48_W) ? TIME_BITS : OUT48_W;
	localparam int MUL_P_W = MUL_A_W + CNT32_W;
	localparam int DIV_D_W = (TIME_BITS > CNT32_W) ? TIME_BITS : CNT32_W;
	localparam int DIV_Q_W = AREA_W + FRAC_BITS;
	localparam int TERM_W  = AREA_W - FRAC_BITS;

	// Stored state.
	logic [COUNT_BITS-1:0] in_sys_q;
	logic [COUNT_BITS-1:0] peak_q;
	logic [CNT32_W-1:0]    arr_cnt_q;
	logic [CNT32_W-1:0]    dep_cnt_q;
	logic [TIME_BITS-1:0]  last_occ_q;
	logic [TIME_BITS-1:0]  last_arr_q;
	logic [TIME_BITS-1:0]  last_dep_q;
	logic [AREA_W-1:0]     occ_area_q;
	logic [AREA_W-1:0]     arr_area_q;
	logic [AREA_W-1:0]     dep_area_q;
	logic [BUSY_W-1:0]     busy_q;

	// Current word and report temporaries.
	req_kind_t            kind_q;
	logic [TIME_BITS-1:0] t_q;
	logic [SVC_W-1:0]     svc_q;
	logic [AREA_W-1:0]    occ_x_q;
	logic [AREA_W-1:0]    arr_x_q;
	logic [AREA_W-1:0]    dep_x_q;
	logic [OUT48_W-1:0]   mis_q;
	logic [OUT48_W-1:0]   mt_q;
	logic [OUT32_W-1:0]   lam_q;
	logic [OUT32_W-1:0]   util_q;
	logic [TERM_W-1:0]    term_q;
	logic                 sat_q;

	// Result register.
	logic [OUT48_W-1:0]        out_mis_q;
	logic [OUT48_W-1:0]        out_mt_q;
	logic [OUT32_W-1:0]        out_lam_q;
	logic signed [OUT48_W-1:0] out_err_q;
	logic [OUT32_W-1:0]        out_util_q;
	logic [PEAK_W-1:0]         out_peak_q;
	status_t                   out_status_q;
	logic                      out_sat_q;

	logic [TIME_BITS-1:0] last_sel;
	logic                 t_gt;
	logic [TIME_BITS-1:0] span;
	logic [CNT32_W-1:0]   mul_b;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_P_W-1:0]   mul_prod;
	logic                 mul_done;
	logic                 prod_over;
	logic [AREA_W-1:0]    prod64;
	logic [AREA_W-1:0]    area_sel;
	logic [AREA_W:0]      area_sum;
	logic [AREA_W-1:0]    ext;

	logic [AREA_W-1:0]  wait_area;
	logic [AREA_W-1:0]  div_num;
	logic [DIV_D_W-1:0] div_den;
	logic [DIV_Q_W-1:0] div_quo;
	logic               div_done;
	logic               den_zero;
	logic               over48;
	logic               over32;
	logic [OUT48_W-1:0] q48;
	logic [OUT32_W-1:0] q32;
	logic               div_clip;

	logic [COUNT_BITS-1:0] in_sys_inc;
	logic [CNT32_W-1:0]    arr_cnt_inc;
	logic [CNT32_W-1:0]    dep_cnt_inc;
	logic [BUSY_W:0]       busy_sum;
	logic [BUSY_W-1:0]     busy_next;

	logic [AREA_W-1:0]  mis64;
	logic [AREA_W-1:0]  term64;
	logic [AREA_W-1:0]  err_pos;
	logic [AREA_W-1:0]  err_neg;
	logic               err_ge;
	logic               err_over;
	logic [OUT48_W-1:0] err_val;
	status_t            status_next;

	// Multiplier operands: elapsed span times count, or rate times mean time.
	always_comb begin
		case (cmd.mul_sel)
			SEL_OCC: begin
				last_sel = last_occ_q;
				mul_b    = CNT32_W'(in_sys_q);
				area_sel = occ_area_q;
			end
			SEL_ARR: begin
				last_sel = last_arr_q;
				mul_b    = arr_cnt_q;
				area_sel = arr_area_q;
			end
			SEL_DEP: begin
				last_sel = last_dep_q;
				mul_b    = dep_cnt_q;
				area_sel = dep_area_q;
			end
			default: begin
				last_sel = last_dep_q;
				mul_b    = lam_q;
				area_sel = '0;
			end
		endcase
	end

	assign t_gt  = t_q > last_sel;
	assign span  = t_gt ? (t_q - last_sel) : '0;
	assign mul_a = (cmd.mul_sel == SEL_TERM) ? MUL_A_W'(mt_q) : MUL_A_W'(span);

	qolm_mul #(
		.A_W(MUL_A_W)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.prod  (mul_prod),
		.done  (mul_done)
	);

	assign prod_over = |mul_prod[MUL_P_W-1:AREA_W];
	assign prod64    = prod_over ? '1 : mul_prod[AREA_W-1:0];
	assign area_sum  = {1'b0, area_sel} + {1'b0, prod64};
	assign ext       = area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];

	// Divider operands.
	assign wait_area = (arr_x_q > dep_x_q) ? (arr_x_q - dep_x_q) : '0;

	always_comb begin
		case (cmd.div_sel)
			QS_MIS: begin
				div_num = occ_x_q;
				div_den = DIV_D_W'(t_q);
			end
			QS_MT: begin
				div_num = wait_area;
				div_den = DIV_D_W'(arr_cnt_q);
			end
			QS_LAM: begin
				div_num = AREA_W'(arr_cnt_q);
				div_den = DIV_D_W'(t_q);
			end
			default: begin
				div_num = AREA_W'(busy_q);
				div_den = DIV_D_W'(t_q);
			end
		endcase
	end

	qolm_div #(
		.NUM_W (AREA_W),
		.DEN_W (DIV_D_W),
		.FRAC_W(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.done  (div_done)
	);

	assign den_zero = div_den == '0;
	assign over48   = |div_quo[DIV_Q_W-1:OUT48_W];
	assign over32   = |div_quo[DIV_Q_W-1:OUT32_W];
	assign q48      = den_zero ? '0 : (over48 ? '1 : div_quo[OUT48_W-1:0]);
	assign q32      = den_zero ? '0 : (over32 ? '1 : div_quo[OUT32_W-1:0]);
	assign div_clip = !den_zero
		&& (((cmd.div_sel == QS_MIS) || (cmd.div_sel == QS_MT)) ? over48 : over32);

	// Saturating count updates.
	assign in_sys_inc  = (in_sys_q == '1) ? in_sys_q : (in_sys_q + COUNT_BITS'(1));
	assign arr_cnt_inc = (arr_cnt_q == '1) ? arr_cnt_q : (arr_cnt_q + CNT32_W'(1));
	assign dep_cnt_inc = (dep_cnt_q == '1) ? dep_cnt_q : (dep_cnt_q + CNT32_W'(1));
	assign busy_sum    = {1'b0, busy_q} + (BUSY_W+1)'(svc_q);
	assign busy_next   = busy_sum[BUSY_W] ? '1 : busy_sum[BUSY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sys_q   <= '0;
			peak_q     <= '0;
			arr_cnt_q  <= '0;
			dep_cnt_q  <= '0;
			last_occ_q <= '0;
			last_arr_q <= '0;
			last_dep_q <= '0;
			occ_area_q <= '0;
			arr_area_q <= '0;
			dep_area_q <= '0;
			busy_q     <= '0;
		end else begin
			if (mul_done && !cmd.report) begin
				case (cmd.mul_sel)
					SEL_OCC: begin
						occ_area_q <= ext;
						if (t_gt) begin
							last_occ_q <= t_q;
						end
					end
					SEL_ARR: begin
						arr_area_q <= ext;
						if (t_gt) begin
							last_arr_q <= t_q;
						end
					end
					SEL_DEP: begin
						dep_area_q <= ext;
						if (t_gt) begin
							last_dep_q <= t_q;
						end
					end
					default: ;
				endcase
			end
			if (cmd.count_update) begin
				case (kind_q)
					KIND_ARRIVAL: begin
						in_sys_q  <= in_sys_inc;
						arr_cnt_q <= arr_cnt_inc;
						busy_q    <= busy_next;
						if (in_sys_inc > peak_q) begin
							peak_q <= in_sys_inc;
						end
					end
					KIND_DEPART: begin
						in_sys_q  <= in_sys_q - COUNT_BITS'(1);
						dep_cnt_q <= dep_cnt_inc;
						busy_q    <= busy_next;
					end
					default: ;
				endcase
			end
		end
	end

	// Little's law error, clipped to the signed 48-bit range.
	assign mis64   = AREA_W'(mis_q);
	assign term64  = AREA_W'(term_q);
	assign err_ge  = mis64 >= term64;
	assign err_pos = mis64 - term64;
	assign err_neg = term64 - mis64;

	always_comb begin
		if (err_ge) begin
			err_over = err_pos > ERR_POS_MAX;
			err_val  = err_over ? ERR_POS_MAX[OUT48_W-1:0] : err_pos[OUT48_W-1:0];
		end else begin
			err_over = err_neg > ERR_NEG_MAG;
			err_val  = OUT48_W'(0)
				- (err_over ? ERR_NEG_MAG[OUT48_W-1:0] : err_neg[OUT48_W-1:0]);
		end
	end

	always_comb begin
		if (t_q == '0) begin
			status_next = STATUS_ZERO_TIME;
		end else if (arr_cnt_q == '0) begin
			status_next = STATUS_NO_ARRIVALS;
		end else begin
			status_next = STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			kind_q <= req_kind_t'(in_kind);
			t_q    <= TIME_BITS'(in_time);
			svc_q  <= in_svc;
			sat_q  <= 1'b0;
		end
		if (mul_done && cmd.report) begin
			case (cmd.mul_sel)
				SEL_OCC:  occ_x_q <= ext;
				SEL_ARR:  arr_x_q <= ext;
				SEL_DEP:  dep_x_q <= ext;
				default: begin
					term_q <= TERM_W'(prod64 >> FRAC_BITS);
					if (prod_over) begin
						sat_q <= 1'b1;
					end
				end
			endcase
		end
		if (div_done) begin
			case (cmd.div_sel)
				QS_MIS:  mis_q  <= q48;
				QS_MT:   mt_q   <= q48;
				QS_LAM:  lam_q  <= q32;
				default: util_q <= q32;
			endcase
			if (div_clip) begin
				sat_q <= 1'b1;
			end
		end
		if (cmd.out_load) begin
			out_mis_q    <= mis_q;
			out_mt_q     <= mt_q;
			out_lam_q    <= lam_q;
			out_err_q    <= err_val;
			out_util_q   <= util_q;
			out_peak_q   <= PEAK_W'(peak_q);
			out_status_q <= status_next;
			out_sat_q    <= sat_q | err_over;
		end
	end

	assign stat.mul_done = mul_done;
	assign stat.div_done = div_done;
	assign stat.kind     = kind_q;
	assign stat.empty    = in_sys_q == '0;

	assign mean_in_system      = out_mis_q;
	assign mean_time_in_system = out_mt_q;
	assign arrival_rate        = out_lam_q;
	assign little_error        = out_err_q;
	assign utilization         = out_util_q;
	assign peak_in_system      = out_peak_q;
	assign status              = out_status_q;
	assign saturated           = out_sat_q;

endmodule

`default_nettype wire

// ===== hdl/qolm_ctrl.sv =====
// Controller of the queue occupancy monitor: sequences the multiplier and divider
// runs for each word and owns both handshakes. Depends on qolm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qolm_ctrl
	import qolm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	output cmd_t  cmd,
	input  stat_t stat
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL_OCC,
		ST_MUL_ARR,
		ST_MUL_DEP,
		ST_COUNT,
		ST_DIV_MIS,
		ST_DIV_MT,
		ST_DIV_LAM,
		ST_DIV_UTIL,
		ST_MUL_TERM,
		ST_DELIVER,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   s_tready_q;
	logic   m_tvalid_q;
	cmd_t   cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			s_tready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
			cmd_q      <= '0;
		end else begin
			cmd_q.mul_start    <= 1'b0;
			cmd_q.div_start    <= 1'b0;
			cmd_q.count_update <= 1'b0;
			cmd_q.out_load     <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready_q) begin
						s_tready_q <= 1'b0;
						state_q    <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (stat.kind)
						KIND_ARRIVAL, KIND_REPORT: begin
							cmd_q.report    <= stat.kind == KIND_REPORT;
							cmd_q.mul_sel   <= SEL_OCC;
							cmd_q.mul_start <= 1'b1;
							state_q         <= ST_MUL_OCC;
						end
						KIND_DEPART: begin
							if (stat.empty) begin
								s_tready_q <= 1'b1;
								state_q    <= ST_IDLE;
							end else begin
								cmd_q.report    <= 1'b0;
								cmd_q.mul_sel   <= SEL_OCC;
								cmd_q.mul_start <= 1'b1;
								state_q         <= ST_MUL_OCC;
							end
						end
						default: begin
							s_tready_q <= 1'b1;
							state_q    <= ST_IDLE;
						end
					endcase
				end
				ST_MUL_OCC: begin
					if (stat.mul_done) begin
						cmd_q.mul_start <= 1'b1;
						if (stat.kind == KIND_DEPART) begin
							cmd_q.mul_sel <= SEL_DEP;
							state_q       <= ST_MUL_DEP;
						end else begin
							cmd_q.mul_sel <= SEL_ARR;
							state_q       <= ST_MUL_ARR;
						end
					end
				end
				ST_MUL_ARR: begin
					if (stat.mul_done) begin
						if (cmd_q.report) begin
							cmd_q.mul_sel   <= SEL_DEP;
							cmd_q.mul_start <= 1'b1;
							state_q         <= ST_MUL_DEP;
						end else begin
							cmd_q.count_update <= 1'b1;
							state_q            <= ST_COUNT;
						end
					end
				end
				ST_MUL_DEP: begin
					if (stat.mul_done) begin
						if (cmd_q.report) begin
							cmd_q.div_sel   <= QS_MIS;
							cmd_q.div_start <= 1'b1;
							state_q         <= ST_DIV_MIS;
						end else begin
							cmd_q.count_update <= 1'b1;
							state_q            <= ST_COUNT;
						end
					end
				end
				ST_COUNT: begin
					s_tready_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_DIV_MIS: begin
					if (stat.div_done) begin
						cmd_q.div_sel   <= QS_MT;
						cmd_q.div_start <= 1'b1;
						state_q         <= ST_DIV_MT;
					end
				end
				ST_DIV_MT: begin
					if (stat.div_done) begin
						cmd_q.div_sel   <= QS_LAM;
						cmd_q.div_start <= 1'b1;
						state_q         <= ST_DIV_LAM;
					end
				end
				ST_DIV_LAM: begin
					if (stat.div_done) begin
						cmd_q.div_sel   <= QS_UTIL;
						cmd_q.div_start <= 1'b1;
						state_q         <= ST_DIV_UTIL;
					end
				end
				ST_DIV_UTIL: begin
					if (stat.div_done) begin
						cmd_q.mul_sel   <= SEL_TERM;
						cmd_q.mul_start <= 1'b1;
						state_q         <= ST_MUL_TERM;
					end
				end
				ST_MUL_TERM: begin
					if (stat.mul_done) begin
						state_q <= ST_DELIVER;
					end
				end
				ST_DELIVER: begin
					if (!m_tvalid_q || m_tready) begin
						cmd_q.out_load <= 1'b1;
						state_q        <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					m_tvalid_q <= 1'b1;
					s_tready_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					s_tready_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;
	assign cmd      = cmd_q;

endmodule

`default_nettype wire

// ===== hdl/queue_occupancy_little_monitor.sv =====
// Queue occupancy monitor after Little's law. Each input word is an arrival, a
// departure or a report request with its time stamp; arrivals and departures update
// the occupancy, arrival and departure counts and their time-weighted areas through
// a shared 16-bit-per-cycle multiplier, and produce no output word. A report extends
// the areas to its own time without storing them and returns one word with mean
// occupancy, mean time in system, arrival rate, Little's law error and utilization
// in fixed point with FRAC_BITS fraction bits, peak occupancy as an integer, plus a
// status code and a clip flag. A report runs the bit-serial divider four times, one
// quotient bit per cycle. A finished report waits in the output register while the
// next word is accepted. Depends on qolm_pkg, qolm_ctrl and qolm_dp.
`timescale 1ns / 1ps
`default_nettype none

module queue_occupancy_little_monitor
	import qolm_pkg::*;
#(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// Fields from bit 0: event_time[31:0], service_ticks[55:32].
	input  logic [S_TDATA_W-1:0] s_tdata,
	// Fields from bit 0: req_type[1:0].
	input  logic [KIND_W-1:0]    s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// Fields from bit 0: mean_in_system[47:0], mean_time_in_system[95:48],
	// arrival_rate[127:96], little_error[175:128], utilization[207:176],
	// peak_in_system[223:208].
	output logic [M_TDATA_W-1:0] m_tdata,
	// Fields from bit 0: status[1:0], saturated[2].
	output logic [M_TUSER_W-1:0] m_tuser
);

	cmd_t  cmd;
	stat_t stat;
	logic  in_load;

	logic [OUT48_W-1:0]        mean_in_system;
	logic [OUT48_W-1:0]        mean_time_in_system;
	logic [OUT32_W-1:0]        arrival_rate;
	logic signed [OUT48_W-1:0] little_error;
	logic [OUT32_W-1:0]        utilization;
	logic [PEAK_W-1:0]         peak_in_system;
	status_t                   status;
	logic                      saturated;

	assign in_load = s_tvalid && s_tready;

	qolm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	qolm_dp #(
		.TIME_BITS (TIME_BITS),
		.COUNT_BITS(COUNT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_load            (in_load),
		.in_kind            (s_tuser),
		.in_time            (s_tdata[IN_TIME_W-1:0]),
		.in_svc             (s_tdata[IN_TIME_W +: SVC_W]),
		.cmd                (cmd),
		.stat               (stat),
		.mean_in_system     (mean_in_system),
		.mean_time_in_system(mean_time_in_system),
		.arrival_rate       (arrival_rate),
		.little_error       (little_error),
		.utilization        (utilization),
		.peak_in_system     (peak_in_system),
		.status             (status),
		.saturated          (saturated)
	);

	assign m_tdata = {peak_in_system, utilization, little_error, arrival_rate,
		mean_time_in_system, mean_in_system};
	assign m_tuser = {saturated, status};

endmodule

`default_nettype wire

// ===== hdl/qolm_checker.sv =====
// Port-level checker for the queue occupancy monitor, bound to the top level.
// Depends on qolm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module qolm_checker
	import qolm_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser
);

	`QOLM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
	`QOLM_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
	`QOLM_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "second word accepted while one is in work")
	`QOLM_ASSERT_NOW(a_zero_time, clk, arst_n, m_tvalid && (m_tuser[1:0] == STATUS_ZERO_TIME), (m_tdata[47:0] == 48'd0) && (m_tdata[127:96] == 32'd0) && (m_tdata[175:128] == 48'd0) && (m_tdata[207:176] == 32'd0), "zero elapsed time with nonzero averages")
	`QOLM_ASSERT_NOW(a_no_arrivals, clk, arst_n, m_tvalid && (m_tuser[1:0] == STATUS_NO_ARRIVALS), (m_tdata[95:48] == 48'd0) && (m_tdata[127:96] == 32'd0), "no arrivals with nonzero rate or time in system")

endmodule

bind queue_occupancy_little_monitor qolm_checker u_qolm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire
